/* hdl/pwcl_pkg.sv */
// Shared constants, types and helper functions for the posterize block with circular lens.
// No dependencies; every other file imports this package.
package pwcl_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;

    localparam int COORD_W  = 12;
    localparam int CHAN_W   = 8;
    localparam int LEVELS_W = 8;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int MULT_W   = 25;
    localparam int SQ_W     = 2 * COORD_W;

    // ceil(2^24 / 255): exact floor division by 255 for 16-bit dividends.
    localparam logic [16:0] RECIP_255 = 17'd65794;

    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENS_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENS_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd3;

    typedef struct packed {
        logic              busy;
        logic [MULT_W-1:0] mult;
    } t_recip_out;

    // Round to the nearest multiple of 64, halves up, saturating at 255.
    function automatic logic [CHAN_W-1:0] lens_quant(input logic [CHAN_W-1:0] c);
        logic [CHAN_W:0] v;
        v = {1'b0, c} + 9'd32;
        if (v[CHAN_W]) begin
            lens_quant = 8'hFF;
        end else begin
            lens_quant = {v[7:6], 6'b0};
        end
    endfunction

endpackage

/* hdl/pwcl_recip.sv */
// Bit-serial reciprocal unit: computes ceil(2^24 / span) one quotient bit per cycle.
// Depends on pwcl_pkg.
module pwcl_recip (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pwcl_pkg::LEVELS_W-1:0]  i_span,
    output pwcl_pkg::t_recip_out           o_status
);
    import pwcl_pkg::*;

    logic [MULT_W-1:0]   r_num;
    logic [LEVELS_W-1:0] r_rem;
    logic [LEVELS_W-1:0] r_div;
    logic [4:0]          r_cnt;

    logic [LEVELS_W:0]   rem_sh;
    logic                ge;

    assign rem_sh = {r_rem, r_num[MULT_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 5'(MULT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= (MULT_W'(1) << (MULT_W - 1)) + MULT_W'(i_span) - MULT_W'(1);
            r_rem <= '0;
            r_div <= i_span;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[MULT_W-2:0], ge};
            r_rem <= ge ? LEVELS_W'(rem_sh - {1'b0, r_div}) : LEVELS_W'(rem_sh);
        end
    end

    assign o_status.busy = (r_cnt != '0);
    assign o_status.mult = r_num;

endmodule

/* hdl/pwcl_geom.sv */
// Three-stage lens membership test: offsets, squares, then sum and compare to radius squared.
// Depends on pwcl_pkg.
module pwcl_geom (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [pwcl_pkg::COORD_W-1:0]  i_px,
    input  logic [pwcl_pkg::COORD_W-1:0]  i_py,
    input  logic [pwcl_pkg::COORD_W-1:0]  i_lens_x,
    input  logic [pwcl_pkg::COORD_W-1:0]  i_lens_y,
    input  logic [pwcl_pkg::SQ_W-1:0]     i_r2,
    output logic                          o_in_lens
);
    import pwcl_pkg::*;

    logic signed [COORD_W:0]     n_dx, n_dy;
    logic signed [COORD_W:0]     r_dx, r_dy;
    logic                        r_inf1, r_inf2, r_in;
    logic signed [2*COORD_W+1:0] dx2_full, dy2_full;
    logic [SQ_W-1:0]             r_dx2, r_dy2;
    logic [SQ_W:0]               d2;

    assign n_dx = $signed({1'b0, i_px}) - $signed({1'b0, i_lens_x});
    assign n_dy = $signed({1'b0, i_py}) - $signed({1'b0, i_lens_y});
    assign dx2_full = r_dx * r_dx;
    assign dy2_full = r_dy * r_dy;
    assign d2 = {1'b0, r_dx2} + {1'b0, r_dy2};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_inf1 <= ({1'b0, i_px} < (COORD_W+1)'(FRAME_WIDTH)) &&
                      ({1'b0, i_py} < (COORD_W+1)'(FRAME_HEIGHT));
            r_dx2  <= dx2_full[SQ_W-1:0];
            r_dy2  <= dy2_full[SQ_W-1:0];
            r_inf2 <= r_inf1;
            r_in   <= r_inf2 && (d2 <= {1'b0, i_r2});
        end
    end

    assign o_in_lens = r_in;

endmodule

/* hdl/pwcl_chan.sv */
// Three-stage posterizer for one color channel, plus the lens value carried alongside.
// Depends on pwcl_pkg.
module pwcl_chan (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [pwcl_pkg::CHAN_W-1:0]    i_c,
    input  logic [pwcl_pkg::LEVELS_W-1:0]  i_span,
    input  logic [pwcl_pkg::MULT_W-1:0]    i_mult,
    output logic [pwcl_pkg::CHAN_W-1:0]    o_post,
    output logic [pwcl_pkg::CHAN_W-1:0]    o_lens
);
    import pwcl_pkg::*;

    logic [15:0]       r_cl;
    logic [CHAN_W-1:0] r_k, r_q;
    logic [CHAN_W-1:0] r_lv1, r_lv2, r_lv3;
    logic [15:0]       z;
    logic [32:0]       kprod;
    logic [15:0]       x;
    logic [40:0]       qprod;

    assign z     = r_cl + 16'd127;
    assign kprod = 33'(z) * 33'(RECIP_255);
    assign x     = {r_k, 8'b0} - {8'b0, r_k};
    assign qprod = 41'(x) * 41'(i_mult);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cl  <= 16'(i_c) * 16'(i_span);
            r_lv1 <= lens_quant(i_c);
            r_k   <= kprod[31:24];
            r_lv2 <= r_lv1;
            r_q   <= qprod[31:24];
            r_lv3 <= r_lv2;
        end
    end

    assign o_post = r_q;
    assign o_lens = r_lv3;

endmodule

/* hdl/posterize_with_circular_lens.sv */
// Top level of the posterize block with circular lens: config registers, input skid, output stage.
// Depends on pwcl_pkg, pwcl_recip, pwcl_geom and pwcl_chan.
//
// Channel   Direction  tdata (low bit first)                          tuser
// s_axis    in         pixel_x[11:0] pixel_y[23:12] red, green, blue  -
// m_axis    out        out_red[7:0] out_green[15:8] out_blue[23:16]   in_lens
// cfg       in         index 0 levels, 1 lens_x, 2 lens_y, 3 radius   -
//
// One beat is accepted per cycle while s_axis_tready is high; each result is registered through the
// pipeline stages and the output stage. After reset and after every write of levels, the reciprocal
// unit restarts, and s_axis_tready stays low until it is done.
// A stall on the output holds the whole pipeline; one input beat is caught in a skid register.
module posterize_with_circular_lens (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [pwcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pwcl_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // pixel_x, pixel_y, red, green, blue
    input  logic [47:0]                     i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0]                     o_m_axis_tdata,
    // in_lens
    output logic [0:0]                      o_m_axis_tuser
);
    import pwcl_pkg::*;

    logic [LEVELS_W-1:0] r_levels;
    logic [COORD_W-1:0]  r_lens_x, r_lens_y, r_radius;
    logic [SQ_W-1:0]     r_r2;
    logic                r_start;
    logic [LEVELS_W-1:0] span;
    t_recip_out          recip;

    logic                r_skid_v;
    logic [47:0]         r_skid_data;
    logic                in_acc, in_v, en;
    logic [47:0]         in_data;
    logic                r_v1, r_v2, r_v3, r_ov;
    logic [23:0]         r_out_data;
    logic                r_out_lens;

    logic                in_lens;
    logic [CHAN_W-1:0]   post_r, post_g, post_b;
    logic [CHAN_W-1:0]   lens_r, lens_g, lens_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= 8'd4;
            r_lens_x <= '0;
            r_lens_y <= '0;
            r_radius <= 12'd100;
            r_start  <= 1'b1;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_LEVELS: begin
                        r_levels <= i_cfg_data[LEVELS_W-1:0];
                        r_start  <= 1'b1;
                    end
                    REG_LENS_X: r_lens_x <= i_cfg_data;
                    REG_LENS_Y: r_lens_y <= i_cfg_data;
                    REG_RADIUS: r_radius <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= SQ_W'(r_radius) * SQ_W'(r_radius);
    end

    assign span = (r_levels < 8'd2) ? 8'd1 : r_levels - 8'd1;

    pwcl_recip u_recip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_span   (span),
        .o_status (recip)
    );

    assign o_s_axis_tready = !r_skid_v && !r_start && !recip.busy;
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign en      = !r_ov || i_m_axis_tready;
    assign in_v    = r_skid_v || in_acc;
    assign in_data = r_skid_v ? r_skid_data : i_s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (in_acc && !en) begin
            r_skid_v <= 1'b1;
        end else if (en) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !en) begin
            r_skid_data <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= in_v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    pwcl_geom u_geom (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_px      (in_data[11:0]),
        .i_py      (in_data[23:12]),
        .i_lens_x  (r_lens_x),
        .i_lens_y  (r_lens_y),
        .i_r2      (r_r2),
        .o_in_lens (in_lens)
    );

    pwcl_chan u_chan_r (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_c    (in_data[31:24]),
        .i_span (span),
        .i_mult (recip.mult),
        .o_post (post_r),
        .o_lens (lens_r)
    );

    pwcl_chan u_chan_g (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_c    (in_data[39:32]),
        .i_span (span),
        .i_mult (recip.mult),
        .o_post (post_g),
        .o_lens (lens_g)
    );

    pwcl_chan u_chan_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_c    (in_data[47:40]),
        .i_span (span),
        .i_mult (recip.mult),
        .o_post (post_b),
        .o_lens (lens_b)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= in_lens ? {lens_b, lens_g, lens_r} : {post_b, post_g, post_r};
            r_out_lens <= in_lens;
        end
    end

    assign o_m_axis_tvalid   = r_ov;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_lens;

endmodule

/* hdl/pwcl_checker.sv */
// Port-level checker for the posterize block with circular lens, and its bind to the top level.
// Depends on pwcl_pkg and posterize_with_circular_lens.
module pwcl_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [pwcl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                            o_s_axis_tready,
    input  logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [23:0]                     o_m_axis_tdata,
    input  logic [0:0]                      o_m_axis_tuser
);
    import pwcl_pkg::*;

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    // The reciprocal unit is started right after reset, so no beat may be taken.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready right after reset");

    // A new level count restarts the reciprocal unit.
    a_levels_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en && (i_cfg_index == REG_LEVELS) |=> !o_s_axis_tready)
        else $error("input ready right after a levels write");

    // Inside the lens every channel is a multiple of 64 or saturated.
    a_lens_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            ((o_m_axis_tdata[5:0] == 6'd0) || (o_m_axis_tdata[7:0] == 8'hFF)) &&
            ((o_m_axis_tdata[13:8] == 6'd0) || (o_m_axis_tdata[15:8] == 8'hFF)) &&
            ((o_m_axis_tdata[21:16] == 6'd0) || (o_m_axis_tdata[23:16] == 8'hFF)))
        else $error("lens channel off the 64 grid");

endmodule

bind posterize_with_circular_lens pwcl_checker u_pwcl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_wr_en     (i_cfg_wr_en),
    .i_cfg_index     (i_cfg_index),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* verif/pwcl_result_check.sv */
// Result checker for posterize_with_circular_lens: watches the config port and both streams.
// Predicts each output pixel from the accepted input beat and compares it in order.
// Depends on pwcl_pkg for widths, frame size and register indexes.
module pwcl_result_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pwcl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pwcl_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    // pixel_x, pixel_y, red, green, blue
    input  logic [47:0]                    i_s_axis_tdata,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // out_red, out_green, out_blue
    input  logic [23:0]                    i_m_axis_tdata,
    // in_lens
    input  logic [0:0]                     i_m_axis_tuser,
    output int                             o_errors,
    output int                             o_pending
);
    import pwcl_pkg::*;

    localparam int SCORE_DEPTH = 256;

    typedef struct packed {
        logic              in_lens;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel_result;

    t_pixel_result         expected_pixels [SCORE_DEPTH];
    int                    wr_count    = 0;
    int                    rd_count    = 0;
    int                    error_count = 0;
    logic [LEVELS_W-1:0]   levels_r  = 8'd4;
    logic [COORD_W-1:0]    lens_x_r  = '0;
    logic [COORD_W-1:0]    lens_y_r  = '0;
    logic [COORD_W-1:0]    radius_r  = 12'd100;

    assign o_errors  = error_count;
    assign o_pending = wr_count - rd_count;

    function automatic logic [CHAN_W-1:0] level_step(input logic [CHAN_W-1:0] c);
        int unsigned span;
        int unsigned k;
        int unsigned cv;
        cv   = c;
        span = (levels_r < 2) ? 1 : levels_r - 1;
        k    = (2 * cv * span + 255) / 510;
        return CHAN_W'((k * 255) / span);
    endfunction

    function automatic logic [CHAN_W-1:0] lens_step(input logic [CHAN_W-1:0] c);
        int unsigned v;
        v = ((c + 32) / 64) * 64;
        return (v > 255) ? 8'hFF : CHAN_W'(v);
    endfunction

    function automatic bit in_circle(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        longint ox;
        longint oy;
        longint cx;
        longint cy;
        longint rr;
        if (px >= FRAME_WIDTH || py >= FRAME_HEIGHT) return 1'b0;
        ox = px;
        oy = py;
        cx = lens_x_r;
        cy = lens_y_r;
        rr = radius_r;
        return ((ox - cx) * (ox - cx) + (oy - cy) * (oy - cy)) <= rr * rr;
    endfunction

    function automatic t_pixel_result quantize_pixel(input logic [47:0] beat);
        t_pixel_result res;
        res.in_lens = in_circle(beat[11:0], beat[23:12]);
        if (res.in_lens) begin
            res.red   = lens_step(beat[31:24]);
            res.green = lens_step(beat[39:32]);
            res.blue  = lens_step(beat[47:40]);
        end else begin
            res.red   = level_step(beat[31:24]);
            res.green = level_step(beat[39:32]);
            res.blue  = level_step(beat[47:40]);
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            levels_r = 8'd4;
            lens_x_r = '0;
            lens_y_r = '0;
            radius_r = 12'd100;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_pixels[wr_count % SCORE_DEPTH] = quantize_pixel(i_s_axis_tdata);
                wr_count++;
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (wr_count == rd_count) begin
                    error_count++;
                    $display("%0t: result with nothing expected, tdata %h tuser %b",
                             $time, i_m_axis_tdata, i_m_axis_tuser);
                end else begin
                    want = expected_pixels[rd_count % SCORE_DEPTH];
                    rd_count++;
                    check_field("out_red", want.red, i_m_axis_tdata[7:0]);
                    check_field("out_green", want.green, i_m_axis_tdata[15:8]);
                    check_field("out_blue", want.blue, i_m_axis_tdata[23:16]);
                    check_field("in_lens", want.in_lens, i_m_axis_tuser[0]);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_LEVELS: levels_r = i_cfg_data[LEVELS_W-1:0];
                    REG_LENS_X: lens_x_r = i_cfg_data[COORD_W-1:0];
                    REG_LENS_Y: lens_y_r = i_cfg_data[COORD_W-1:0];
                    REG_RADIUS: radius_r = i_cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* verif/tb_top.sv */
// Testbench top for posterize_with_circular_lens: clock, reset, config phases and stream traffic.
// Instantiates the block and pwcl_result_check, which predicts and compares every result.
// Depends on pwcl_pkg, the block's RTL and verif/pwcl_result_check.sv.
module tb_top;
    import pwcl_pkg::*;

    localparam int NUM_PHASES   = 11;
    localparam int PHASE_PIXELS = 155;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_STALL   = 300;
    localparam int RUN_LIMIT    = 2_000_000;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_W-1:0]     i_cfg_data      = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [47:0]          i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [23:0]          o_m_axis_tdata;
    logic [0:0]           o_m_axis_tuser;

    bit src_idle      = 1'b0;
    bit sink_idle     = 1'b0;
    bit stall_request = 1'b0;
    int cur_lx        = 0;
    int cur_ly        = 0;
    int cur_rad       = 100;
    int errors;
    int pending;

    posterize_with_circular_lens dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    pwcl_result_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (!src_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [7:0] rand_chan();
        logic [7:0] corner_vals [8] = '{8'd0, 8'd31, 8'd32, 8'd127, 8'd128, 8'd223, 8'd224,
                                        8'd255};
        if ($urandom_range(0, 7) == 0) return corner_vals[$urandom_range(0, 7)];
        return 8'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input int lv, input int lx, input int ly, input int rad);
        wait_drained();
        write_reg(REG_LEVELS, {4'($urandom), 8'(lv)});
        write_reg(REG_LENS_X, 12'(lx));
        write_reg(REG_LENS_Y, 12'(ly));
        write_reg(REG_RADIUS, 12'(rad));
        cur_lx  = lx;
        cur_ly  = ly;
        cur_rad = rad;
    endtask

    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {b, g, r, py, px};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random_pixel();
        int          pick;
        int          span;
        logic [11:0] px;
        logic [11:0] py;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            span = (cur_rad > 600) ? 600 : cur_rad;
            px   = 12'(cur_lx + int'($urandom_range(0, 2 * span + 4)) - span - 2);
            py   = 12'(cur_ly + int'($urandom_range(0, 2 * span + 4)) - span - 2);
        end else if (pick < 8) begin
            px = 12'($urandom_range(0, FRAME_WIDTH - 1));
            py = 12'($urandom_range(0, FRAME_HEIGHT - 1));
        end else begin
            px = 12'($urandom);
            py = 12'($urandom);
        end
        send_pixel(px, py, rand_chan(), rand_chan(), rand_chan());
    endtask

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                i_m_axis_tready = 1'b0;
                repeat (LONG_STALL) @(negedge i_clk);
                stall_request = 1'b0;
            end else if (!sink_idle) begin
                i_m_axis_tready = 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else begin
                hold = $urandom_range(0, 99);
                if (hold < 60) begin
                    i_m_axis_tready = 1'b1;
                    hold = $urandom_range(0, 8);
                end else if (hold < 95) begin
                    i_m_axis_tready = 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    i_m_axis_tready = 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin
        int lv;
        int lx;
        int ly;
        int rad;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Settings straight out of reset: four levels, lens of radius 100 at the origin.
        send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255);
        send_pixel(12'd0, 12'd0, 8'd31, 8'd32, 8'd95);
        send_pixel(12'd0, 12'd0, 8'd96, 8'd223, 8'd224);
        send_pixel(12'd100, 12'd0, 8'd1, 8'd2, 8'd3);
        send_pixel(12'd101, 12'd0, 8'd42, 8'd43, 8'd127);
        send_pixel(12'd60, 12'd80, 8'd128, 8'd212, 8'd213);
        send_pixel(12'd61, 12'd80, 8'd128, 8'd212, 8'd213);
        send_pixel(12'd0, 12'd100, 8'd170, 8'd85, 8'd254);
        send_pixel(12'd639, 12'd479, 8'd42, 8'd43, 8'd127);
        send_pixel(12'd640, 12'd0, 8'd128, 8'd212, 8'd213);
        send_pixel(12'd0, 12'd480, 8'd255, 8'd0, 8'd1);
        send_pixel(12'd4095, 12'd4095, 8'd255, 8'd0, 8'd170);

        // Zero radius at the frame corner, and a levels value below the minimum.
        configure(1, 639, 479, 0);
        send_pixel(12'd639, 12'd479, 8'd200, 8'd100, 8'd33);
        send_pixel(12'd638, 12'd479, 8'd127, 8'd128, 8'd0);
        send_pixel(12'd639, 12'd478, 8'd255, 8'd1, 8'd254);

        // Lens centre beyond the right edge of the frame, with the most levels.
        configure(255, 700, 400, 100);
        send_pixel(12'd640, 12'd400, 8'd10, 8'd20, 8'd30);
        send_pixel(12'd639, 12'd400, 8'd160, 8'd224, 8'd223);
        send_pixel(12'd0, 12'd0, 8'd1, 8'd254, 8'd128);
        send_pixel(12'd2048, 12'd1024, 8'hAA, 8'h55, 8'hFF);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: lv = 2;
                1: lv = 255;
                2: lv = 0;
                3: lv = 1;
                4: lv = 3;
                default: lv = $urandom_range(0, 255);
            endcase
            if (p == 1) begin
                lx = 4095;
                ly = 4095;
            end else if (p == 2) begin
                lx = 0;
                ly = 0;
            end else begin
                lx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 700);
                ly = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(0, 520);
            end
            if (p == 1 || p == 4) begin
                rad = 4095;
            end else if (p == 3) begin
                rad = 0;
            end else begin
                rad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(1, 300);
            end
            configure(lv, lx, ly, rad);
            src_idle  = (p % 3 != 0) && (p != 5);
            sink_idle = (p % 4 != 1);
            if (p == 5) begin
                stall_request = 1'b1;
            end
            repeat (PHASE_PIXELS) send_random_pixel();
        end

        wait_drained();
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
hdl/pwcl_pkg.sv
hdl/pwcl_recip.sv
hdl/pwcl_geom.sv
hdl/pwcl_chan.sv
hdl/posterize_with_circular_lens.sv
hdl/pwcl_checker.sv
verif/pwcl_result_check.sv
verif/tb_top.sv
